// ===== src/morse_keyer_segments_defines.svh =====
// Assertion macros used by the top module to check its own logic.
`ifndef MORSE_KEYER_SEGMENTS_DEFINES_SVH
`define MORSE_KEYER_SEGMENTS_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MKS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mks_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mks_pkg;

    // Segment kinds as they appear on the result channel
    localparam logic [2:0] KIND_DOT        = 3'd0;
    localparam logic [2:0] KIND_DASH       = 3'd1;
    localparam logic [2:0] KIND_ELEM_GAP   = 3'd2;
    localparam logic [2:0] KIND_LETTER_GAP = 3'd3;
    localparam logic [2:0] KIND_WORD_GAP   = 3'd4;

    // Segment lengths in time units
    localparam logic [2:0] LEN_DOT        = 3'd1;
    localparam logic [2:0] LEN_DASH       = 3'd3;
    localparam logic [2:0] LEN_ELEM_GAP   = 3'd1;
    localparam logic [2:0] LEN_LETTER_GAP = 3'd3;
    localparam logic [2:0] LEN_WORD_GAP   = 3'd7;

    // Character codes
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'd48;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'd57;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    // Element patterns, first element in bit 0, a set bit is a dash
    localparam logic [4:0] LETTER_BITS [26] = '{
        5'b00010, 5'b00001, 5'b00101, 5'b00001, 5'b00000, 5'b00100,
        5'b00011, 5'b00000, 5'b00000, 5'b01110, 5'b00101, 5'b00010,
        5'b00011, 5'b00001, 5'b00111, 5'b00110, 5'b01011, 5'b00010,
        5'b00000, 5'b00001, 5'b00100, 5'b01000, 5'b00110, 5'b01001,
        5'b01101, 5'b00011
    };
    localparam logic [2:0] LETTER_LEN [26] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
        3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
        3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };
    localparam logic [4:0] DIGIT_BITS [10] = '{
        5'b11111, 5'b11110, 5'b11100, 5'b11000, 5'b10000,
        5'b00000, 5'b00001, 5'b00011, 5'b00111, 5'b01111
    };
    localparam logic [2:0] DIGIT_LEN = 3'd5;

    // Character classes that steer the first jump of the program
    typedef enum logic [1:0] {
        CLS_MORSE,
        CLS_SPACE,
        CLS_OTHER
    } mks_cls_t;

    typedef struct packed {
        mks_cls_t   cls;
        logic [2:0] count;
        logic [4:0] bits;
    } mks_code_t;

    // Program steps
    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_ELEM,
        STEP_EGAP,
        STEP_LGAP,
        STEP_WORD
    } mks_step_t;

    // Jump conditions
    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_DISPATCH,
        JMP_MORE
    } mks_jmp_t;

    // One control word of the program
    typedef struct packed {
        logic       take;
        logic       emit;
        logic       sel_elem;
        logic       shift;
        logic       level;
        logic [2:0] len;
        logic [2:0] kind;
        logic       last;
        mks_jmp_t   jmp;
        mks_step_t  target;
    } mks_uword_t;

    // Control from sequencer to datapath
    typedef struct packed {
        logic       ready;
        logic       load;
        logic       fire;
        logic       sel_elem;
        logic       shift;
        logic       level;
        logic [2:0] len;
        logic [2:0] kind;
        logic       last;
    } mks_ctrl_t;

    // Status from datapath to sequencer
    typedef struct packed {
        mks_cls_t cls;
        logic     slot_free;
        logic     more;
    } mks_stat_t;

    // Fold case and look up the element pattern of a character
    function automatic mks_code_t mks_lookup(input logic [7:0] c);
        logic [7:0] u;
        logic [4:0] li;
        logic [3:0] di;
        mks_code_t  r;
        u = c;
        if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]})
            u = c - CASE_OFFSET;
        li = 5'(u - CHAR_UPPER_A);
        di = 4'(u - CHAR_DIGIT_0);
        r.cls   = CLS_OTHER;
        r.count = 3'd0;
        r.bits  = 5'd0;
        if (u inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})
        begin
            r.cls   = CLS_MORSE;
            r.count = LETTER_LEN[li];
            r.bits  = LETTER_BITS[li];
        end
        else if (u inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]})
        begin
            r.cls   = CLS_MORSE;
            r.count = DIGIT_LEN;
            r.bits  = DIGIT_BITS[di];
        end
        else if (u == CHAR_SPACE)
        begin
            r.cls = CLS_SPACE;
        end
        return r;
    endfunction

    // Program store
    function automatic mks_uword_t mks_ucode(input mks_step_t s);
        mks_uword_t w;
        w = '{take: 1'b0, emit: 1'b0, sel_elem: 1'b0, shift: 1'b0, level: 1'b0,
              len: LEN_LETTER_GAP, kind: KIND_LETTER_GAP, last: 1'b0,
              jmp: JMP_ALWAYS, target: STEP_IDLE};
        case (s)
            STEP_IDLE:
            begin
                w.take = 1'b1;
                w.jmp  = JMP_DISPATCH;
            end
            STEP_ELEM:
            begin
                w.emit     = 1'b1;
                w.sel_elem = 1'b1;
                w.level    = 1'b1;
                w.jmp      = JMP_NEXT;
            end
            STEP_EGAP:
            begin
                w.emit   = 1'b1;
                w.shift  = 1'b1;
                w.len    = LEN_ELEM_GAP;
                w.kind   = KIND_ELEM_GAP;
                w.jmp    = JMP_MORE;
                w.target = STEP_ELEM;
            end
            STEP_LGAP:
            begin
                w.emit   = 1'b1;
                w.last   = 1'b1;
                w.target = STEP_IDLE;
            end
            STEP_WORD:
            begin
                w.emit   = 1'b1;
                w.len    = LEN_WORD_GAP;
                w.kind   = KIND_WORD_GAP;
                w.target = STEP_LGAP;
            end
            default:
            begin
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== src/mks_char_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface mks_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface
`default_nettype wire

// ===== src/mks_seg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface mks_seg_if;
    logic       valid;
    logic       ready;
    logic       key_level;
    logic [2:0] length_units;
    logic [2:0] segment_kind;
    logic       last_segment;

    modport source (output valid, output key_level, output length_units,
                    output segment_kind, output last_segment, input ready);
    modport sink (input valid, input key_level, input length_units,
                  input segment_kind, input last_segment, output ready);
endinterface
`default_nettype wire

// ===== src/morse_keyer_segments.sv =====
// Channel   Dir  Payload                                              Handshake
// char_in   in   char_code[7:0]                                       valid/ready
// seg_out   out  key_level, length_units[2:0], segment_kind[2:0],     valid/ready
//                last_segment
//
// The idle step takes in a character; each later step gives one segment: a letter gap for
// an unsupported code, a word gap then a letter gap for a space, and a dot or dash plus an
// element gap per element, then a letter gap, for a letter or digit. char_in is ready only in the idle step.
// A stalled seg_out holds the current segment and freezes the program.
// Reset clears the step counter and the result valid flag.
`timescale 1ns / 1ps
`default_nettype none
`include "morse_keyer_segments_defines.svh"
module morse_keyer_segments
    import mks_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    mks_char_if.sink  char_in,
    mks_seg_if.source seg_out
);

    mks_ctrl_t ctrl;
    mks_stat_t stat;

    mks_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (char_in.valid),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    mks_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (char_in.char_code),
        .ctrl      (ctrl),
        .stat      (stat),
        .seg_out   (seg_out)
    );

    assign char_in.ready = ctrl.ready;

    // Busy after a request is taken
    `MKS_ASSERT_NEXT(a_busy_after_take, clk, rst_n, char_in.valid && char_in.ready, !char_in.ready, "block ready right after taking a character")
    // Final segment is always the letter gap
    `MKS_ASSERT_NOW(a_last_is_lgap, clk, rst_n, seg_out.valid && seg_out.last_segment, (seg_out.segment_kind == KIND_LETTER_GAP) && (seg_out.length_units == LEN_LETTER_GAP), "final segment is not a letter gap")
    // Key is on exactly for dots and dashes
    `MKS_ASSERT_NOW(a_level_kind, clk, rst_n, seg_out.valid, seg_out.key_level == ((seg_out.segment_kind == KIND_DOT) || (seg_out.segment_kind == KIND_DASH)), "key level disagrees with segment kind")

endmodule
`default_nettype wire

// ===== src/mks_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mks_sequencer
    import mks_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire mks_stat_t stat,
    output mks_ctrl_t      ctrl
);

    mks_step_t  step_reg;
    mks_step_t  step_next;
    mks_uword_t uw;
    logic       advance;

    // Fetch the control word and decide whether the step completes
    always_comb
    begin
        uw = mks_ucode(step_reg);
        if (uw.emit)
            advance = stat.slot_free;
        else if (uw.take)
            advance = in_valid;
        else
            advance = 1'b1;
    end

    // Next step: sequential, jump, dispatch on class, or loop on elements
    always_comb
    begin
        step_next = step_reg;
        if (advance)
        begin
            case (uw.jmp)
                JMP_NEXT:     step_next = mks_step_t'(step_reg + 3'd1);
                JMP_ALWAYS:   step_next = uw.target;
                JMP_DISPATCH:
                begin
                    case (stat.cls)
                        CLS_MORSE: step_next = STEP_ELEM;
                        CLS_SPACE: step_next = STEP_WORD;
                        default:   step_next = STEP_LGAP;
                    endcase
                end
                JMP_MORE:
                begin
                    if (stat.more)
                        step_next = uw.target;
                    else
                        step_next = mks_step_t'(step_reg + 3'd1);
                end
                default:      step_next = STEP_IDLE;
            endcase
        end
    end

    // Drive the datapath from the control word
    always_comb
    begin
        ctrl.ready    = uw.take;
        ctrl.load     = uw.take & in_valid;
        ctrl.fire     = uw.emit & stat.slot_free;
        ctrl.sel_elem = uw.sel_elem;
        ctrl.shift    = uw.shift;
        ctrl.level    = uw.level;
        ctrl.len      = uw.len;
        ctrl.kind     = uw.kind;
        ctrl.last     = uw.last;
    end

    // Hold the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_IDLE;
        else
            step_reg <= step_next;
    end

endmodule
`default_nettype wire

// ===== src/mks_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mks_datapath
    import mks_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] char_code,
    input  wire mks_ctrl_t  ctrl,
    output mks_stat_t       stat,
    mks_seg_if.source       seg_out
);

    mks_code_t  code;
    logic [4:0] bits_reg;
    logic [4:0] bits_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       valid_reg;
    logic       valid_next;
    logic       level_reg;
    logic [2:0] len_reg;
    logic [2:0] kind_reg;
    logic       last_reg;
    logic       dash;

    // Decode the incoming character
    always_comb
    begin
        code = mks_lookup(char_code);
    end

    // Element pattern and remaining count: load on request, drop one per element gap
    always_comb
    begin
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        if (ctrl.load)
        begin
            bits_next = code.bits;
            cnt_next  = code.count;
        end
        else if (ctrl.fire && ctrl.shift)
        begin
            bits_next = bits_reg >> 1;
            cnt_next  = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        cnt_reg  <= cnt_next;
    end

    // Result register: hold until taken, refill in the same cycle
    assign valid_next = ctrl.fire | (valid_reg & ~seg_out.ready);
    assign dash       = bits_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fire)
        begin
            level_reg <= ctrl.level;
            last_reg  <= ctrl.last;
            if (ctrl.sel_elem)
            begin
                len_reg  <= dash ? LEN_DASH : LEN_DOT;
                kind_reg <= dash ? KIND_DASH : KIND_DOT;
            end
            else
            begin
                len_reg  <= ctrl.len;
                kind_reg <= ctrl.kind;
            end
        end
    end

    assign seg_out.valid        = valid_reg;
    assign seg_out.key_level    = level_reg;
    assign seg_out.length_units = len_reg;
    assign seg_out.segment_kind = kind_reg;
    assign seg_out.last_segment = last_reg;

    // Report to the sequencer
    always_comb
    begin
        stat.cls       = code.cls;
        stat.slot_free = ~valid_reg | seg_out.ready;
        stat.more      = (cnt_reg != 3'd1);
    end

endmodule
`default_nettype wire
